// ===== design/w19_pkg.sv =====
// ---------------------------------------------------------------------------
// w19_pkg: shared definitions for the WELL19937a generator
// Sizes, step offsets, operation codes, datapath action codes, the
// controller/datapath interface structs and the index wrap helper.
// ---------------------------------------------------------------------------
package w19_pkg;

    // State store geometry and step offsets
    localparam int STATE_WORDS  = 624;
    localparam int ADDR_W       = 10;
    localparam int OFFSET_ONE   = 70;
    localparam int OFFSET_TWO   = 179;
    localparam int OFFSET_THREE = 449;

    // Words that a finish with no loaded words writes from the default seed
    localparam logic [ADDR_W-1:0] DEFAULT_WORDS = ADDR_W'(2);

    // Arithmetic constants
    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] MSB_MASK  = 32'h8000_0000;
    localparam logic [31:0] LOW_MASK  = 32'h7FFF_FFFF;
    localparam logic [5:0]  WORD_BITS = 6'd32;

    // Operation codes of an input beat
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_GEN    = 2'd2;

    // Datapath action codes issued by the controller
    localparam int ACT_W = 5;
    localparam logic [ACT_W-1:0] ACT_NONE      = 5'd0;
    localparam logic [ACT_W-1:0] ACT_CLR_WR    = 5'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_WR   = 5'd2;
    localparam logic [ACT_W-1:0] ACT_FILL_INIT = 5'd3;
    localparam logic [ACT_W-1:0] ACT_DEF_HI    = 5'd4;
    localparam logic [ACT_W-1:0] ACT_DEF_LO    = 5'd5;
    localparam logic [ACT_W-1:0] ACT_FILL_RD   = 5'd6;
    localparam logic [ACT_W-1:0] ACT_FILL_MUL  = 5'd7;
    localparam logic [ACT_W-1:0] ACT_FILL_WR   = 5'd8;
    localparam logic [ACT_W-1:0] ACT_FIN_END   = 5'd9;
    localparam logic [ACT_W-1:0] ACT_GEN_RD0   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_GEN_RD1   = 5'd11;
    localparam logic [ACT_W-1:0] ACT_GEN_RD2   = 5'd12;
    localparam logic [ACT_W-1:0] ACT_GEN_CALC  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_GEN_WR0   = 5'd14;
    localparam logic [ACT_W-1:0] ACT_GEN_WR1   = 5'd15;
    localparam logic [ACT_W-1:0] ACT_GEN_WR2   = 5'd16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept;    // input beat taken this cycle
        logic [ACT_W-1:0] act;       // datapath action
        logic             out_load;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_zero;  // no seed words loaded
        logic idx_end;     // sweep index has reached the end of the store
    } t_stat;

    // Add an offset to a store index, wrapping at the store size.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] add);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, add};
        if (sum >= (ADDR_W+1)'(STATE_WORDS)) begin
            sum = sum - (ADDR_W+1)'(STATE_WORDS);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/well19937a_generator.sv =====
// ---------------------------------------------------------------------------
// well19937a_generator: WELL19937a pseudo-random generator
// 624-word state store seeded by load and finish beats; generate beats
// return the top bits of each new word.
//
//   Channel   Direction  Signals                               Beat
//   input     in         i_in_valid/o_in_ready, operation,     one operation
//                        seed_word, bits
//   output    out        o_out_valid/i_out_ready, o_value      one result
//   config    in         i_cfg_we, i_cfg_wdata                 default seed
//
// After reset a clearing pass zeroes the store; no input beat is taken
// during it, configuration writes are taken at any time. The generate
// sequence is set by the six store reads and three writes through one
// write and two read ports. A finish reads, multiplies and writes each
// filled word in turn, as each word of the seed fill depends on an
// earlier word. One beat is worked on at a time; a new beat is taken
// while the previous result still waits in the output register.
// ---------------------------------------------------------------------------
module well19937a_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_seed_word,
    input  logic [5:0]  i_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata
);
    import w19_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing controller
    w19_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Store and arithmetic
    w19_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seed_word (i_seed_word),
        .i_bits      (i_bits),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_value     (o_value)
    );

endmodule

// ===== design/w19_ctrl.sv =====
// ---------------------------------------------------------------------------
// w19_ctrl: sequencing controller
// Runs the clearing pass, the load, finish and generate sequences, and the
// input and output handshakes. Drives the datapath with one action a cycle.
// ---------------------------------------------------------------------------
module w19_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_operation,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output w19_pkg::t_cmd o_cmd,
    input  w19_pkg::t_stat i_stat
);
    import w19_pkg::*;

    // State codes
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_CLEAR    = 5'd1;
    localparam logic [4:0] ST_LOAD     = 5'd2;
    localparam logic [4:0] ST_FIN_INIT = 5'd3;
    localparam logic [4:0] ST_FIN_HI   = 5'd4;
    localparam logic [4:0] ST_FIN_LO   = 5'd5;
    localparam logic [4:0] ST_FILL_RD  = 5'd6;
    localparam logic [4:0] ST_FILL_MUL = 5'd7;
    localparam logic [4:0] ST_FILL_WR  = 5'd8;
    localparam logic [4:0] ST_GEN_RD0  = 5'd9;
    localparam logic [4:0] ST_GEN_RD1  = 5'd10;
    localparam logic [4:0] ST_GEN_RD2  = 5'd11;
    localparam logic [4:0] ST_GEN_CALC = 5'd12;
    localparam logic [4:0] ST_GEN_WR0  = 5'd13;
    localparam logic [4:0] ST_GEN_WR1  = 5'd14;
    localparam logic [4:0] ST_GEN_WR2  = 5'd15;
    localparam logic [4:0] ST_DONE     = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and datapath command
    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_out_ready;
        o_cmd.accept     = in_acc;
        o_cmd.act        = ACT_NONE;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_LOAD:   n_state = ST_LOAD;
                        OP_FINISH: n_state = ST_FIN_INIT;
                        OP_GEN:    n_state = ST_GEN_RD0;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (i_stat.idx_end) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.act = ACT_CLR_WR;
                end
            end
            ST_LOAD: begin
                o_cmd.act = ACT_LOAD_WR;
                n_state   = ST_DONE;
            end
            ST_FIN_INIT: begin
                o_cmd.act = ACT_FILL_INIT;
                n_state   = i_stat.count_zero ? ST_FIN_HI : ST_FILL_RD;
            end
            ST_FIN_HI: begin
                o_cmd.act = ACT_DEF_HI;
                n_state   = ST_FIN_LO;
            end
            ST_FIN_LO: begin
                o_cmd.act = ACT_DEF_LO;
                n_state   = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.act = ACT_FIN_END;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.act = ACT_FILL_RD;
                    n_state   = ST_FILL_MUL;
                end
            end
            ST_FILL_MUL: begin
                o_cmd.act = ACT_FILL_MUL;
                n_state   = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                o_cmd.act = ACT_FILL_WR;
                n_state   = ST_FILL_RD;
            end
            ST_GEN_RD0: begin
                o_cmd.act = ACT_GEN_RD0;
                n_state   = ST_GEN_RD1;
            end
            ST_GEN_RD1: begin
                o_cmd.act = ACT_GEN_RD1;
                n_state   = ST_GEN_RD2;
            end
            ST_GEN_RD2: begin
                o_cmd.act = ACT_GEN_RD2;
                n_state   = ST_GEN_CALC;
            end
            ST_GEN_CALC: begin
                o_cmd.act = ACT_GEN_CALC;
                n_state   = ST_GEN_WR0;
            end
            ST_GEN_WR0: begin
                o_cmd.act = ACT_GEN_WR0;
                n_state   = ST_GEN_WR1;
            end
            ST_GEN_WR1: begin
                o_cmd.act = ACT_GEN_WR1;
                n_state   = ST_GEN_WR2;
            end
            ST_GEN_WR2: begin
                o_cmd.act = ACT_GEN_WR2;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // An accepted beat closes the input until its sequence is done.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // A result only appears at the end of a sequence.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output valid raised outside the done state");

    // A finished result waits while the previous one is still held.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && r_out_valid && !i_out_ready |=> (r_state == ST_DONE))
        else $error("result handed over while output register was full");

endmodule

// ===== design/w19_dpath.sv =====
// ---------------------------------------------------------------------------
// w19_dpath: state store and arithmetic
// Holds the 624-word store (one write port, two registered read ports),
// the step index, the load count, the seed fill multiplier, the WELL
// recurrence logic and the result registers.
// ---------------------------------------------------------------------------
module w19_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [63:0]    i_cfg_wdata,
    input  logic [31:0]    i_seed_word,
    input  logic [5:0]     i_bits,
    input  w19_pkg::t_cmd  i_cmd,
    output w19_pkg::t_stat o_stat,
    output logic [31:0]    o_value
);
    import w19_pkg::*;

    // State store
    logic [31:0] r_mem [0:STATE_WORDS-1];
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    // Control registers
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_count;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_fcnt;

    // Payload registers
    logic [63:0] r_seed;
    logic [31:0] r_seed_word;
    logic [5:0]  r_bits;
    logic [31:0] r_prod;
    logic [31:0] r_v0;
    logic [31:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] r_m3;
    logic [31:0] r_z3;
    logic [31:0] r_z4;
    logic [31:0] r_keep;
    logic [31:0] r_result;
    logic [31:0] r_out_value;

    // Derived addresses and datapath signals
    logic [ADDR_W-1:0] addr_m1;
    logic [ADDR_W-1:0] addr_m2;
    logic [ADDR_W-1:0] addr_m3;
    logic [ADDR_W-1:0] addr_rm1;
    logic [ADDR_W-1:0] addr_rm2;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] fill_start;
    logic              count_full;
    logic [31:0]       mix;
    logic [31:0]       z0;
    logic [31:0]       z1;
    logic [31:0]       z2;
    logic [31:0]       z3;
    logic [31:0]       z4;
    logic [5:0]        bits_clamp;
    logic [5:0]        shift;

    // Neighbor addresses of the current step
    assign addr_m1  = wrap_add(r_pos, ADDR_W'(OFFSET_ONE));
    assign addr_m2  = wrap_add(r_pos, ADDR_W'(OFFSET_TWO));
    assign addr_m3  = wrap_add(r_pos, ADDR_W'(OFFSET_THREE));
    assign addr_rm1 = wrap_add(r_pos, ADDR_W'(STATE_WORDS - 1));
    assign addr_rm2 = wrap_add(r_pos, ADDR_W'(STATE_WORDS - 2));

    assign count_full = (r_count == ADDR_W'(STATE_WORDS));
    assign fill_start = (r_count == '0) ? DEFAULT_WORDS : r_count;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.idx_end    = (r_idx == ADDR_W'(STATE_WORDS));

    // Seed mixing term: p xor (p arithmetic-shifted right by 30)
    assign mix = r_rd_a ^ {{30{r_rd_a[31]}}, r_rd_a[31:30]};

    // WELL19937a recurrence step from the captured words and the trailing pair
    always_comb begin
        z0 = (MSB_MASK & r_rd_a) ^ (LOW_MASK & r_rd_b);
        z1 = (r_v0 ^ (r_v0 << 25)) ^ (r_m1 ^ (r_m1 >> 27));
        z2 = (r_m2 >> 9) ^ (r_m3 ^ (r_m3 >> 1));
        z3 = z1 ^ z2;
        z4 = z0 ^ (z1 ^ (z1 << 9)) ^ (z2 ^ (z2 << 21)) ^ (z3 ^ (z3 >> 21));
    end

    // Top bits of the new word; a shift of the full width gives zero.
    assign bits_clamp = (r_bits > WORD_BITS) ? WORD_BITS : r_bits;
    assign shift      = WORD_BITS - bits_clamp;

    // Read address selection for both ports
    always_comb begin
        rd_addr_a = r_pos;
        rd_addr_b = addr_m1;
        case (i_cmd.act)
            ACT_FILL_RD: begin
                rd_addr_a = r_idx - r_fcnt;
            end
            ACT_GEN_RD1: begin
                rd_addr_a = addr_m2;
                rd_addr_b = addr_m3;
            end
            ACT_GEN_RD2: begin
                rd_addr_a = addr_rm1;
                rd_addr_b = addr_rm2;
            end
            default: begin
                rd_addr_a = r_pos;
                rd_addr_b = addr_m1;
            end
        endcase
    end

    // Write port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        case (i_cmd.act)
            ACT_CLR_WR: begin
                wr_en = 1'b1;
            end
            ACT_LOAD_WR: begin
                wr_en   = !count_full;
                wr_addr = r_count;
                wr_data = r_seed_word;
            end
            ACT_DEF_HI: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_seed[63:32];
            end
            ACT_DEF_LO: begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(1);
                wr_data = r_seed[31:0];
            end
            ACT_FILL_WR: begin
                wr_en   = 1'b1;
                wr_data = r_prod + {{(32-ADDR_W){1'b0}}, r_idx};
            end
            ACT_GEN_WR0: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_z3;
            end
            ACT_GEN_WR1: begin
                wr_en   = 1'b1;
                wr_addr = addr_rm1;
                wr_data = r_z4;
            end
            ACT_GEN_WR2: begin
                wr_en   = 1'b1;
                wr_addr = addr_rm2;
                wr_data = r_keep;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Store: one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Step index, load count and sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_fcnt  <= '0;
        end else begin
            case (i_cmd.act)
                ACT_CLR_WR: begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
                ACT_LOAD_WR: begin
                    if (!count_full) begin
                        r_count <= r_count + ADDR_W'(1);
                    end
                end
                ACT_FILL_INIT: begin
                    r_fcnt <= fill_start;
                    r_idx  <= fill_start;
                end
                ACT_FILL_WR: begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
                ACT_FIN_END: begin
                    r_pos   <= '0;
                    r_count <= '0;
                end
                ACT_GEN_WR2: begin
                    r_pos <= addr_rm1;
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // Input capture, fill product, step captures and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seed_word <= i_seed_word;
            r_bits      <= i_bits;
            r_result    <= '0;
        end
        if (i_cmd.act == ACT_FILL_MUL) begin
            r_prod <= SEED_MULT * mix;
        end
        if (i_cmd.act == ACT_GEN_RD1) begin
            r_v0 <= r_rd_a;
            r_m1 <= r_rd_b;
        end
        if (i_cmd.act == ACT_GEN_RD2) begin
            r_m2 <= r_rd_a;
            r_m3 <= r_rd_b;
        end
        if (i_cmd.act == ACT_GEN_CALC) begin
            r_z3     <= z3;
            r_z4     <= z4;
            r_keep   <= MSB_MASK & r_rd_b;
            r_result <= z4 >> shift;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_result;
        end
    end

    assign o_value = r_out_value;

    // The step index always names a word of the store.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < ADDR_W'(STATE_WORDS))
        else $error("step index outside the store");

    // The load count saturates at the store size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ADDR_W'(STATE_WORDS))
        else $error("load count beyond the store size");

    // Store writes never pass the end of the store.
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr < ADDR_W'(STATE_WORDS)))
        else $error("store write outside the store");

endmodule

// ===== tb/well19937a_generator_tb.sv =====
// ---------------------------------------------------------------------------
// well19937a_generator_tb: self-checking bench for the WELL19937a generator
// A short table of directed beats covers the zero store, bit-count extremes,
// seeding from the default seed and from loaded words, and the unused
// operation. Random seeding runs and generate bursts follow, in phases with
// different default seeds and different idle and stall patterns on both
// channels. Every result beat is checked against a shadow copy of the
// generator state kept in the bench or against a typed row's fixed value.
// ---------------------------------------------------------------------------
module well19937a_generator_tb;
    import w19_pkg::*;

    // Operation code that the block accepts and ignores
    localparam logic [1:0]  OP_NONE         = 2'd3;
    localparam logic [31:0] FILL_MULT       = 32'd1812433253;
    localparam logic [31:0] TOP_BIT         = 32'h8000_0000;
    localparam int          DIRECTED_ROWS   = 23;
    localparam int          ITEMS_PER_PHASE = 500;
    localparam int          PHASES          = 4;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int          LIMIT_CYCLES    = 3_000_000;
    localparam int          HALF_PERIOD     = 10;

    typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;

    // One directed beat; typed rows carry a result that needs no prediction.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
        logic [5:0]  nbits;
        logic        typed;
        logic [31:0] value;
    } t_row;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation  = OP_LOAD;
    logic [31:0] i_seed_word  = '0;
    logic [5:0]  i_bits       = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_value;
    logic        i_cfg_we     = 1'b0;
    logic [63:0] i_cfg_wdata  = '0;

    // Shadow copy of the generator state
    logic [31:0] shadow_words [STATE_WORDS];
    int unsigned shadow_pos;
    int unsigned shadow_count;
    logic [63:0] shadow_seed;

    logic [31:0] pending_values [$];
    t_row        directed [DIRECTED_ROWS];
    t_pace       pace           = PACE_FULL;
    int unsigned items_done     = 0;
    int unsigned fail_count     = 0;
    bit          force_overflow = 1'b0;

    well19937a_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_seed_word (i_seed_word),
        .i_bits      (i_bits),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Seed fill recurrence; the shift by 30 sign-extends.
    function automatic logic [31:0] fill_word(input logic [31:0] p, input int unsigned idx);
        logic [31:0] folded;
        folded = p ^ {{30{p[31]}}, p[31:30]};
        return FILL_MULT * folded + 32'(idx);
    endfunction

    // One WELL19937a step on the shadow store; returns the new word z4.
    function automatic logic [31:0] well_step();
        int unsigned rm1;
        int unsigned rm2;
        logic [31:0] v0, m1, m2, m3, z0, z1, z2, z3, z4;
        rm1 = (shadow_pos + STATE_WORDS - 1) % STATE_WORDS;
        rm2 = (shadow_pos + STATE_WORDS - 2) % STATE_WORDS;
        v0  = shadow_words[shadow_pos];
        m1  = shadow_words[(shadow_pos + OFFSET_ONE) % STATE_WORDS];
        m2  = shadow_words[(shadow_pos + OFFSET_TWO) % STATE_WORDS];
        m3  = shadow_words[(shadow_pos + OFFSET_THREE) % STATE_WORDS];
        z0  = (TOP_BIT & shadow_words[rm1]) ^ (~TOP_BIT & shadow_words[rm2]);
        z1  = (v0 ^ (v0 << 25)) ^ (m1 ^ (m1 >> 27));
        z2  = (m2 >> 9) ^ (m3 ^ (m3 >> 1));
        z3  = z1 ^ z2;
        z4  = z0 ^ (z1 ^ (z1 << 9)) ^ (z2 ^ (z2 << 21)) ^ (z3 ^ (z3 >> 21));
        shadow_words[shadow_pos] = z3;
        shadow_words[rm1]        = z4;
        shadow_words[rm2]        = shadow_words[rm2] & TOP_BIT;
        shadow_pos               = rm1;
        return z4;
    endfunction

    // Apply one input beat to the shadow state and return its result value.
    function automatic logic [31:0] well_output(input logic [1:0] op, input logic [31:0] word,
                                                input logic [5:0] nbits);
        int unsigned count;
        int unsigned k;
        int unsigned width;
        logic [31:0] z4;
        logic [31:0] result;
        result = '0;
        case (op)
            OP_LOAD: begin
                if (shadow_count < STATE_WORDS) begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            OP_FINISH: begin
                count = shadow_count;
                // With no loaded words the default seed gives two, high word first.
                if (count == 0) begin
                    shadow_words[0] = shadow_seed[63:32];
                    shadow_words[1] = shadow_seed[31:0];
                    count = 2;
                end
                for (k = count; k < STATE_WORDS; k++) begin
                    shadow_words[k] = fill_word(shadow_words[k - count], k);
                end
                shadow_pos   = 0;
                shadow_count = 0;
            end
            OP_GEN: begin
                z4    = well_step();
                width = (nbits > 6'd32) ? 32 : int'(nbits);
                if (width != 0) begin
                    result = z4 >> (32 - width);
                end
            end
            default: begin
            end
        endcase
        return result;
    endfunction

    // Random hold-off decision for one side in the current pace.
    function automatic bit hold_off(input bit receiver);
        int unsigned percent;
        if (pace == PACE_BOTH) begin
            percent = 9;
        end else if ((pace == PACE_SENDER && !receiver) || (pace == PACE_RECEIVER && receiver)) begin
            percent = 57;
        end else begin
            percent = 0;
        end
        return $urandom_range(99) < percent;
    endfunction

    function automatic logic [31:0] random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return '0;
        end else if (pick < 16) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [5:0] random_nbits();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return 6'd0;
        end else if (pick < 20) begin
            return 6'($urandom_range(63, 33));
        end
        return 6'($urandom_range(32, 1));
    endfunction

    // Send one input beat and queue its expected result once it is taken.
    task automatic send_item(input logic [1:0] op, input logic [31:0] word,
                             input logic [5:0] nbits, input bit typed,
                             input logic [31:0] typed_value);
        logic [31:0] value;
        bit          ignored;
        ignored = (op == OP_NONE) || (op == OP_LOAD && shadow_count >= STATE_WORDS);
        while (hold_off(1'b0)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_seed_word <= word;
        i_bits      <= nbits;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        value = well_output(op, word, nbits);
        pending_values.push_back(typed ? typed_value : value);
        if (!ignored) begin
            items_done++;
        end
    endtask

    // Hold the input side idle until every queued result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_values.size() != 0);
    endtask

    task automatic write_default_seed(input logic [63:0] seed);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_seed = seed;
    endtask

    // One random run: mostly a full seeding followed by a generate burst,
    // otherwise a few beats of any operation with any field values.
    task automatic random_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        pick = $urandom_range(99);
        if (pick < 4) begin
            wait_for_results();
        end
        if (pick < 82 || force_overflow) begin
            pick = $urandom_range(99);
            if (force_overflow || pick == 0) begin
                n = STATE_WORDS + $urandom_range(12);
            end else if (pick < 13) begin
                n = 0;
            end else if (pick < 55) begin
                n = $urandom_range(4, 1);
            end else begin
                n = $urandom_range(40, 5);
            end
            force_overflow = 1'b0;
            for (k = 0; k < n; k++) begin
                send_item(OP_LOAD, random_word(), random_nbits(), 1'b0, '0);
            end
            send_item(OP_FINISH, random_word(), random_nbits(), 1'b0, '0);
            n = $urandom_range(60, 8);
            for (k = 0; k < n; k++) begin
                send_item(OP_GEN, random_word(), random_nbits(), 1'b0, '0);
            end
        end else begin
            n = $urandom_range(8, 1);
            for (k = 0; k < n; k++) begin
                send_item(2'($urandom_range(3)), random_word(), 6'($urandom_range(63)),
                          1'b0, '0);
            end
        end
    endtask

    // Result side: check each result beat, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_values.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result beat: value %h", o_value);
                end
            end else begin
                if (o_value !== pending_values[0]) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("value mismatch: expected %h, got %h",
                                 pending_values[0], o_value);
                    end
                end
                void'(pending_values.pop_front());
            end
        end
        i_out_ready <= !hold_off(1'b1);
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("** well19937a_generator: FAILED **");
        $finish;
    end

    // Stimulus
    initial begin
        int i;
        int ph;
        for (i = 0; i < STATE_WORDS; i++) begin
            shadow_words[i] = '0;
        end
        shadow_pos   = 0;
        shadow_count = 0;
        shadow_seed  = '0;

        // Zero store first, then default seed, loaded words and bit-count edges.
        directed = '{
            '{OP_GEN,    32'h0000_0000, 6'd32, 1'b1, 32'h0},  // store still all zero
            '{OP_GEN,    32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0},
            '{OP_NONE,   32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0},  // ignored operation
            '{OP_FINISH, 32'h0000_0000, 6'd0,  1'b1, 32'h0},  // seed from default
            '{OP_GEN,    32'h0000_0000, 6'd32, 1'b0, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd1,  1'b0, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd0,  1'b1, 32'h0},  // zero bits still steps
            '{OP_GEN,    32'h0000_0000, 6'd33, 1'b0, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd63, 1'b0, 32'h0},
            '{OP_GEN,    32'hA5A5_A5A5, 6'd31, 1'b0, 32'h0},
            '{OP_LOAD,   32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0},
            '{OP_LOAD,   32'h0000_0000, 6'd0,  1'b1, 32'h0},
            '{OP_LOAD,   32'h8000_0000, 6'd32, 1'b1, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd16, 1'b0, 32'h0},  // before finish
            '{OP_FINISH, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd32, 1'b0, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd8,  1'b0, 32'h0},
            '{OP_LOAD,   32'h7FFF_FFFF, 6'd1,  1'b1, 32'h0},  // single seed word
            '{OP_FINISH, 32'h0000_0000, 6'd0,  1'b1, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd32, 1'b0, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd2,  1'b0, 32'h0},
            '{OP_NONE,   32'h0000_0000, 6'd0,  1'b1, 32'h0},
            '{OP_GEN,    32'h0000_0000, 6'd32, 1'b0, 32'h0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_default_seed(64'hFFFF_FFFF_FFFF_FFFF);

        // Directed table
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(directed[i].op, directed[i].word, directed[i].nbits,
                      directed[i].typed, directed[i].value);
        end
        wait_for_results();
        items_done = 0;

        // Random phases, each with its own default seed and pace
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_default_seed(64'h0);
                    pace           = PACE_FULL;
                    force_overflow = 1'b1;
                end
                1: begin
                    write_default_seed({$urandom, $urandom});
                    pace = PACE_SENDER;
                end
                2: begin
                    write_default_seed(64'hFFFF_FFFF_FFFF_FFFF);
                    pace = PACE_RECEIVER;
                end
                default: begin
                    write_default_seed({$urandom, $urandom});
                    pace = PACE_BOTH;
                end
            endcase
            while (items_done < (ph + 1) * ITEMS_PER_PHASE) begin
                random_sequence();
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** well19937a_generator: PASSED **");
        end else begin
            $display("** well19937a_generator: FAILED **");
        end
        $finish;
    end

endmodule
